FILE: design/qrs_pkg.sv
package qrs_pkg;

  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int MW   = CW;
  localparam int PW   = 2 * CW;
  localparam int DW   = 2 * CW + 1;
  localparam int RADW = DW + 2 * FB;
  localparam int SQN  = (RADW + 1) / 2;
  localparam int RADP = 2 * SQN;
  localparam int RW   = SQN + 2;
  localparam int NMW  = ((MW + FB > SQN) ? MW + FB : SQN) + 1;
  localparam int N2W  = NMW + 2;
  localparam int DENW = MW + 1;
  localparam int D2W  = DENW + 1;

  typedef enum logic [1:0] {
    ST_TWO  = 2'd0,
    ST_ONE  = 2'd1,
    ST_NONE = 2'd2
  } st_t;

  typedef struct packed {
    logic            ns;
    logic [NMW-1:0]  nm;
    logic            ds;
    logic [DENW-1:0] dm;
    st_t             st;
  } pay_t;

  typedef struct packed {
    logic [RADP-1:0] x;
    logic [RW-1:0]   rem;
    logic [SQN-1:0]  root;
    pay_t            pay;
  } sq_t;

  typedef struct packed {
    logic           s;
    logic [NMW-1:0] m;
  } sm_t;

  typedef struct packed {
    logic [D2W-1:0] rem;
    logic [CW-1:0]  nlo;
    logic [CW-1:0]  q;
    logic [D2W-1:0] d2;
    logic           s;
    logic           ov;
  } lane_t;

  typedef struct packed {
    lane_t l1;
    lane_t l2;
    st_t   st;
  } dv_t;

  typedef struct packed {
    logic [CW-1:0] v;
    logic          sat;
  } fin_t;

  function automatic sm_t sm_add(input logic ns, input logic [NMW-1:0] nm,
                                 input logic rneg, input logic [SQN-1:0] r);
    sm_t o;
    logic [NMW-1:0] rr;
    rr = NMW'(r);
    if (ns == rneg) begin
      o.s = ns;
      o.m = nm + rr;
    end else if (nm >= rr) begin
      o.s = ns;
      o.m = nm - rr;
    end else begin
      o.s = rneg;
      o.m = rr - nm;
    end
    return o;
  endfunction

  function automatic lane_t lane_prep(input sm_t a, input logic ds,
                                      input logic [DENW-1:0] dm);
    lane_t o;
    logic [N2W-1:0] n2;
    n2    = {a.m, 1'b0} + N2W'(dm);
    o.d2  = {dm, 1'b0};
    o.ov  = D2W'(n2 >> CW) >= o.d2 || (n2 >> CW) >= N2W'(o.d2);
    o.rem = D2W'(n2 >> CW);
    o.nlo = n2[CW-1:0];
    o.q   = '0;
    o.s   = a.s ^ ds;
    return o;
  endfunction

  function automatic lane_t div_step(input lane_t a);
    lane_t o;
    logic [D2W:0] cur;
    logic ge;
    o   = a;
    cur = {a.rem, a.nlo[CW-1]};
    ge  = cur >= {1'b0, a.d2};
    o.rem = ge ? D2W'(cur - {1'b0, a.d2}) : D2W'(cur);
    o.nlo = {a.nlo[CW-2:0], 1'b0};
    o.q   = {a.q[CW-2:0], ge};
    return o;
  endfunction

  function automatic fin_t fin_lane(input lane_t a);
    fin_t o;
    logic [CW-1:0] lim;
    logic [CW-1:0] v;
    lim   = a.s ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    o.sat = a.ov || (a.q > lim);
    v     = o.sat ? lim : a.q;
    o.v   = a.s ? (~v + 1'b1) : v;
    return o;
  endfunction

endpackage

FILE: design/quadratic_root_solver_top.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_coeff_a, in_coeff_b, in_coeff_c
// out     | out_valid | out_stall | out_root_first, out_root_second,
//         |           |           | out_root_status, out_root_saturated
// One item per cycle while the output is not stalled; the pipe is 3 front stages + SQN
// sqrt cells (49) + 2 prep stages + CW divide cells (32) + output register.
// The sqrt and divide chains retire one result bit per cell.
// Synchronous active-low reset clears all valid bits; no clearing pass.
// A held output stalls the whole pipe; in_stall = out_valid & out_stall.
module quadratic_root_solver_top import qrs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [CW-1:0] in_coeff_a,
  input  logic [CW-1:0] in_coeff_b,
  input  logic [CW-1:0] in_coeff_c,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [CW-1:0] out_root_first,
  output logic [CW-1:0] out_root_second,
  output logic [1:0]    out_root_status,
  output logic          out_root_saturated
);

  logic en;
  logic [SQN:0] sv;
  sq_t          sq [SQN+1];
  logic [CW:0]  dvv;
  dv_t          dv [CW+1];

  logic mix_v_r, prep_v_r;
  sm_t  m1_r, m2_r;
  pay_t mp_r;
  dv_t  prep_r;

  logic          ov_r;
  logic [CW-1:0] r1_r, r2_r;
  logic [1:0]    st_r;
  logic          sat_r;
  fin_t          f1, f2;

  assign en       = !ov_r || !out_stall;
  assign in_stall = !en;

  qrs_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .a(in_coeff_a), .b(in_coeff_b), .c(in_coeff_c),
    .o_vld(sv[0]), .o_sq(sq[0])
  );

  for (genvar k = 0; k < SQN; k++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .i_vld(sv[k]), .i_sq(sq[k]), .o_vld(sv[k+1]), .o_sq(sq[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_v_r  <= 1'b0;
      prep_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else if (en) begin
      mix_v_r  <= sv[SQN];
      prep_v_r <= mix_v_r;
      ov_r     <= dvv[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r      <= sm_add(sq[SQN].pay.ns, sq[SQN].pay.nm, 1'b0, sq[SQN].root);
      m2_r      <= sm_add(sq[SQN].pay.ns, sq[SQN].pay.nm, 1'b1, sq[SQN].root);
      mp_r      <= sq[SQN].pay;
      prep_r.l1 <= lane_prep(m1_r, mp_r.ds, mp_r.dm);
      prep_r.l2 <= lane_prep(m2_r, mp_r.ds, mp_r.dm);
      prep_r.st <= mp_r.st;
    end
  end

  assign dvv[0] = prep_v_r;
  assign dv[0]  = prep_r;

  for (genvar k = 0; k < CW; k++) begin : g_dv
    qrs_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .i_vld(dvv[k]), .i_dv(dv[k]), .o_vld(dvv[k+1]), .o_dv(dv[k+1])
    );
  end

  assign f1 = fin_lane(dv[CW].l1);
  assign f2 = fin_lane(dv[CW].l2);

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= dv[CW].st;
      case (dv[CW].st)
        ST_TWO: begin
          r1_r  <= f1.v;
          r2_r  <= f2.v;
          sat_r <= f1.sat | f2.sat;
        end
        ST_ONE: begin
          r1_r  <= f1.v;
          r2_r  <= f1.v;
          sat_r <= f1.sat;
        end
        default: begin
          r1_r  <= '0;
          r2_r  <= '0;
          sat_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_root_first     = r1_r;
  assign out_root_second    = r2_r;
  assign out_root_status    = st_r;
  assign out_root_saturated = sat_r;

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_status == ST_NONE |->
      out_root_first == '0 && out_root_second == '0 && !out_root_saturated)
    else $error("no-root item carries data");

  a_one_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_status == ST_ONE |-> out_root_first == out_root_second)
    else $error("single root differs between fields");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_saturated |->
      out_root_first == {1'b0, {(CW-1){1'b1}}} ||
      out_root_first == {1'b1, {(CW-1){1'b0}}} ||
      out_root_second == {1'b0, {(CW-1){1'b1}}} ||
      out_root_second == {1'b1, {(CW-1){1'b0}}})
    else $error("saturation flag without clipped root");

endmodule

FILE: design/qrs_front.sv
module qrs_front import qrs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [CW-1:0] a,
  input  logic [CW-1:0] b,
  input  logic [CW-1:0] c,
  output logic          o_vld,
  output sq_t           o_sq
);

  logic v0_r, v1_r, v2_r;
  logic sa0_r, sb0_r, sc0_r, sa1_r, sb1_r, sc1_r;
  logic [MW-1:0] ma0_r, mb0_r, mc0_r, ma1_r, mb1_r, mc1_r;
  logic [PW-1:0] bb1_r, ac1_r;
  sq_t sq2_r, sq2_nxt;
  logic [DW-1:0] bb, ac4, d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa0_r <= a[CW-1];
      sb0_r <= b[CW-1];
      sc0_r <= c[CW-1];
      ma0_r <= a[CW-1] ? ~a + 1'b1 : a;
      mb0_r <= b[CW-1] ? ~b + 1'b1 : b;
      mc0_r <= c[CW-1] ? ~c + 1'b1 : c;
      sa1_r <= sa0_r;
      sb1_r <= sb0_r;
      sc1_r <= sc0_r;
      ma1_r <= ma0_r;
      mb1_r <= mb0_r;
      mc1_r <= mc0_r;
      bb1_r <= mb0_r * mb0_r;
      ac1_r <= ma0_r * mc0_r;
      sq2_r <= sq2_nxt;
    end
  end

  always_comb begin
    bb  = DW'(bb1_r);
    ac4 = DW'(ac1_r) << 2;
    d   = '0;
    sq2_nxt = '0;
    if (ma1_r == '0) begin
      sq2_nxt.pay.ns = mc1_r != '0 && !sc1_r;
      sq2_nxt.pay.nm = NMW'(mc1_r) << FB;
      sq2_nxt.pay.ds = sb1_r;
      sq2_nxt.pay.dm = DENW'(mb1_r);
      sq2_nxt.pay.st = (mb1_r != '0) ? ST_ONE : ST_NONE;
    end else begin
      sq2_nxt.pay.ns = mb1_r != '0 && !sb1_r;
      sq2_nxt.pay.nm = NMW'(mb1_r) << FB;
      sq2_nxt.pay.ds = sa1_r;
      sq2_nxt.pay.dm = {ma1_r, 1'b0};
      if (sa1_r != sc1_r && mc1_r != '0) begin
        d = bb + ac4;
        sq2_nxt.pay.st = ST_TWO;
      end else if (bb > ac4) begin
        d = bb - ac4;
        sq2_nxt.pay.st = ST_TWO;
      end else if (bb == ac4) begin
        sq2_nxt.pay.st = ST_ONE;
      end else begin
        sq2_nxt.pay.st = ST_NONE;
      end
    end
    sq2_nxt.x = RADP'(d) << (2 * FB);
  end

  assign o_vld = v2_r;
  assign o_sq  = sq2_r;

endmodule

FILE: design/qrs_sqrt_cell.sv
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic i_vld,
  input  sq_t  i_sq,
  output logic o_vld,
  output sq_t  o_sq
);

  logic v_r;
  sq_t  sq_r, sq_nxt;
  logic [RW+1:0] cur, trial;
  logic ge;

  always_comb begin
    cur    = {i_sq.rem, i_sq.x[RADP-1 -: 2]};
    trial  = {2'b00, i_sq.root, 2'b01};
    ge     = cur >= trial;
    sq_nxt = i_sq;
    sq_nxt.rem  = ge ? RW'(cur - trial) : RW'(cur);
    sq_nxt.root = {i_sq.root[SQN-2:0], ge};
    sq_nxt.x    = i_sq.x << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign o_vld = v_r;
  assign o_sq  = sq_r;

endmodule

FILE: design/qrs_div_cell.sv
module qrs_div_cell import qrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic i_vld,
  input  dv_t  i_dv,
  output logic o_vld,
  output dv_t  o_dv
);

  logic v_r;
  dv_t  dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r.l1 <= div_step(i_dv.l1);
      dv_r.l2 <= div_step(i_dv.l2);
      dv_r.st <= i_dv.st;
    end
  end

  assign o_vld = v_r;
  assign o_dv  = dv_r;

endmodule

FILE: tb/quadratic_root_solver_top_tb.sv
module quadratic_root_solver_top_tb;
  import qrs_pkg::*;

  typedef struct {
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] c;
    bit            drain;
  } coeff_t;

  typedef struct {
    logic [CW-1:0] r1;
    logic [CW-1:0] r2;
    st_t           st;
    logic          sat;
  } roots_t;

  localparam int WDOG_LIMIT = 3000;
  localparam int HOLD_LEN   = 300;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [CW-1:0] in_coeff_a = '0;
  logic [CW-1:0] in_coeff_b = '0;
  logic [CW-1:0] in_coeff_c = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CW-1:0] out_root_first;
  logic [CW-1:0] out_root_second;
  logic [1:0]    out_root_status;
  logic          out_root_saturated;

  coeff_t pending_coeffs[$];
  roots_t expected_roots[$];
  int     mismatches = 0;
  int     tx_gap = 0;
  int     rx_wait = 0;
  int     results_seen = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  int     idle_cycles = 0;

  quadratic_root_solver_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void split(input logic [CW-1:0] v, output bit neg,
                                output logic [127:0] mag);
    neg = v[CW-1];
    mag = neg ? 128'(-$signed({{96{v[CW-1]}}, v})) : 128'(v);
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] round_div(input bit ns, input logic [127:0] nm,
                                              input bit ds, input logic [127:0] dm,
                                              inout logic sat);
    logic [127:0] q;
    logic [127:0] lim;
    bit s;
    q = ((nm << 1) + dm) / (dm << 1);
    s = ns != ds;
    lim = s ? (128'd1 << (CW-1)) : ((128'd1 << (CW-1)) - 1);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return s ? CW'(-q) : CW'(q);
  endfunction

  function automatic void signed_sum(input bit s1, input logic [127:0] m1,
                                     input bit s2, input logic [127:0] m2,
                                     output bit s, output logic [127:0] m);
    if (s1 == s2) begin
      s = s1;
      m = m1 + m2;
    end else if (m1 >= m2) begin
      s = s1;
      m = m1 - m2;
    end else begin
      s = s2;
      m = m2 - m1;
    end
  endfunction

  function automatic roots_t solve_roots(input coeff_t x);
    roots_t o;
    bit sa, sb, sc, nbs, s;
    logic [127:0] ma, mb, mc, bb, ac4, d, nbm, den, rt, m;
    int sgn;
    split(x.a, sa, ma);
    split(x.b, sb, mb);
    split(x.c, sc, mc);
    o.r1 = '0;
    o.r2 = '0;
    o.st = ST_NONE;
    o.sat = 1'b0;
    if (ma == 0) begin
      if (mb != 0) begin
        o.r1 = round_div(mc != 0 && !sc, mc << FB, sb, mb, o.sat);
        o.r2 = o.r1;
        o.st = ST_ONE;
      end
    end else begin
      bb = mb * mb;
      ac4 = (ma * mc) << 2;
      d = '0;
      nbs = mb != 0 && !sb;
      nbm = mb << FB;
      den = ma << 1;
      if (sa != sc && mc != 0) begin
        d = bb + ac4;
        sgn = 1;
      end else begin
        sgn = (bb > ac4) ? 1 : (bb == ac4) ? 0 : -1;
        if (sgn > 0) d = bb - ac4;
      end
      if (sgn == 0) begin
        o.r1 = round_div(nbs, nbm, sa, den, o.sat);
        o.r2 = o.r1;
        o.st = ST_ONE;
      end else if (sgn > 0) begin
        rt = int_sqrt(d << (2*FB));
        signed_sum(nbs, nbm, 1'b0, rt, s, m);
        o.r1 = round_div(s, m, sa, den, o.sat);
        signed_sum(nbs, nbm, 1'b1, rt, s, m);
        o.r2 = round_div(s, m, sa, den, o.sat);
        o.st = ST_TWO;
      end
    end
    return o;
  endfunction

  task automatic report(input string what, input logic [CW-1:0] got,
                        input logic [CW-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_roots.push_back(solve_roots(pending_coeffs.pop_front()));
        tx_gap = $urandom_range(0, 5);
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_coeffs.size() > 0 &&
                     !(pending_coeffs[0].drain && expected_roots.size() > 0)) begin
          in_valid <= 1'b1;
          in_coeff_a <= pending_coeffs[0].a;
          in_coeff_b <= pending_coeffs[0].b;
          in_coeff_c <= pending_coeffs[0].c;
          pending_coeffs[0].drain = 1'b0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    roots_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_roots.size() == 0) begin
          $display("unexpected result item");
          mismatches++;
        end else begin
          want = expected_roots.pop_front();
          if (out_root_first !== want.r1) report("root_first", out_root_first, want.r1);
          if (out_root_second !== want.r2) report("root_second", out_root_second, want.r2);
          if (out_root_status !== want.st) report("root_status", out_root_status, want.st);
          if (out_root_saturated !== want.sat)
            report("root_saturated", out_root_saturated, want.sat);
        end
        rx_wait = $urandom_range(0, 5);
        if (results_seen % 200 < 60) rx_wait = 0;
        if (!hold_done && results_seen == 300) begin
          hold_done = 1'b1;
          hold_left = HOLD_LEN;
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (hold_left > 0) || (rx_wait > 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [CW-1:0] a, input logic [CW-1:0] b,
                          input logic [CW-1:0] c);
    coeff_t x;
    x.a = a;
    x.b = b;
    x.c = c;
    x.drain = 1'b0;
    pending_coeffs.push_back(x);
  endtask

  function automatic logic [CW-1:0] small_val();
    return CW'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
  endfunction

  initial begin
    logic [CW-1:0] ext[4];
    int s, t, kind;
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    add_item(0, 0, 0);
    add_item(0, 0, 32'h0005_0000);
    add_item(0, 32'h0002_0000, 32'h0003_0000);
    add_item(0, 1, 32'h7FFF_FFFF);
    add_item(0, 32'hFFFF_FFFF, 32'h8000_0000);
    add_item(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    add_item(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
    add_item(32'h0001_0000, 0, 32'h0001_0000);
    add_item(1, 32'h7FFF_FFFF, 0);
    add_item(32'hFFFF_0000, 32'h0003_0000, 32'h0004_0000);
    for (int i = 0; i < 4; i++)
      for (int j = 1; j < 4; j += 2)
        add_item(ext[j] | CW'(i == 2), ext[i], ext[3 - i]);
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int n = 0; n < 950; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: add_item($urandom, $urandom, $urandom);
        3, 4: add_item(small_val(), small_val(), small_val());
        5: add_item(0, $urandom_range(0, 1) ? small_val() : $urandom, $urandom);
        6: begin
          s = $urandom_range(1, 300) * ($urandom_range(0, 1) ? 1 : -1);
          t = $signed($urandom_range(0, 600)) - 300;
          add_item(s, 2 * s * t, s * t * t);
        end
        7: add_item($urandom_range(1, 8), $urandom, $urandom_range(0, 8));
        default: add_item(small_val(), $urandom, small_val());
      endcase
      if (n == 500) pending_coeffs[pending_coeffs.size() - 1].drain = 1'b1;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_coeffs.size() > 0 || expected_roots.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
